>>> rtl/cdrs_pkg.sv
// Shared types and constants of the C-SCAN disk request scheduler.
`timescale 1ns / 1ps
package cdrs_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIST_W    = 9;
    localparam int unsigned TOTAL_W   = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_POS  = 2'd1;

    localparam logic [7:0]         MAX_TRACK_RST = 8'd199;
    localparam logic [7:0]         HEAD_POS_RST  = 8'd0;
    localparam logic [TOTAL_W:0]   TOTAL_MAX     = 15'd16383;

    typedef struct packed {
        logic [7:0] track;
        logic       batch_end;
    } t_request;

    typedef struct packed {
        logic [7:0]         served_track;
        logic [DIST_W-1:0]  move_distance;
        logic [TOTAL_W-1:0] total_movement;
        logic               dropped;
        logic               final_res;
    } t_result;

    // classified request handed from the front end to the service engine
    typedef struct packed {
        logic [7:0] track;
        logic       last;
        logic       keep;
        logic       dropped;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } t_back_state;

endpackage

>>> rtl/cscan_disk_request_scheduler.sv
// Top level of the C-SCAN disk request scheduler.
// Request channel: i_req {track, batch_end}, taken when push is high and full
// is low. Each transaction is one track request; the one with batch_end set
// closes the batch and starts service. Requests past MAX_REQUESTS in a batch
// are discarded and every result of that batch then shows dropped.
// Result channel: o_res {served_track, move_distance, total_movement,
// dropped, final_res}, shown while empty is low and taken when pop is high.
// One result per stored request, in C-SCAN order; final_res marks the last.
// Loading: one request per cycle while the engine loads, through a two-entry
// command queue. Service: every result walks the request store through its
// single read port. While a batch is served the front end stops taking
// requests once the command queue holds two.
// A result waits in the output register while pop is low; the engine stalls.
// Configuration: i_cfg_we with i_cfg_idx 0 (max_track) or 1 (head_position),
// written by the user only while idle (not enforced); other indexes ignored.
// Reset (synchronous, active low) clears counts, flags and queues and loads
// max_track 199, head_position 0. The request store is not cleared: only
// entries written in the current batch are ever read.
`timescale 1ns / 1ps
module cscan_disk_request_scheduler import cdrs_pkg::*; #(
    parameter int unsigned MAX_REQUESTS = 32,
    parameter int unsigned TRACK_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_request             i_req,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_max_track;
    logic [7:0] r_head_pos;

    logic    q_push;
    logic    q_pop;
    t_cmd    q_in;
    t_cmd    q_out;
    t_q_stat q_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_track <= MAX_TRACK_RST;
            r_head_pos  <= HEAD_POS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_TRACK: r_max_track <= i_cfg_data;
                CFG_HEAD_POS:  r_head_pos  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: keep or drop, batch fill count
    cdrs_front #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (i_req),
        .i_q_stat (q_stat),
        .o_full   (full),
        .o_q_push (q_push),
        .o_cmd    (q_in)
    );

    // decouples request intake from service
    cdrs_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_stat  (q_stat)
    );

    // store, order selection, distance and totals
    cdrs_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_cmd       (q_out),
        .o_q_pop     (q_pop),
        .i_max_track (r_max_track),
        .i_head_pos  (r_head_pos),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_res)
    );

endmodule

>>> rtl/cdrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cdrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cdrs_front.sv
// Front end: accepts requests, decides keep or drop, tracks batch fill.
`timescale 1ns / 1ps
module cdrs_front import cdrs_pkg::*; #(
    parameter int unsigned MAX_REQUESTS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_request i_req,
    input  t_q_stat  i_q_stat,
    output logic     o_full,
    output logic     o_q_push,
    output t_cmd     o_cmd
);

    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          accept;
    logic          keep;
    logic          ovf_now;

    always_comb begin
        accept  = i_push && !i_q_stat.full;
        keep    = r_cnt < CW'(MAX_REQUESTS);
        ovf_now = r_ovf || !keep;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        if (accept) begin
            if (i_req.batch_end) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_cnt = keep ? r_cnt + CW'(1) : r_cnt;
                n_ovf = ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    // a dropped request that does not close the batch only sets the flag
    assign o_full        = i_q_stat.full;
    assign o_q_push      = accept && (keep || i_req.batch_end);
    assign o_cmd.track   = i_req.track;
    assign o_cmd.last    = i_req.batch_end;
    assign o_cmd.keep    = keep;
    assign o_cmd.dropped = ovf_now;

endmodule

>>> rtl/cdrs_fifo.sv
// Two-entry command queue between the front end and the service engine.
`timescale 1ns / 1ps
module cdrs_fifo import cdrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> rtl/cdrs_back.sv
// Service engine: stores a batch, picks requests in C-SCAN order, builds results.
`timescale 1ns / 1ps
module cdrs_back import cdrs_pkg::*; #(
    parameter int unsigned MAX_REQUESTS = 32,
    parameter int unsigned TRACK_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_cmd       i_cmd,
    output logic       o_q_pop,
    input  logic [7:0] i_max_track,
    input  logic [7:0] i_head_pos,
    input  logic       i_pop,
    output logic       o_empty,
    output t_result    o_res
);

    localparam int unsigned AW = $clog2(MAX_REQUESTS);
    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned KW = (TRACK_BITS > 8) ? TRACK_BITS : 8;
    localparam int unsigned DW = KW + 2;

    t_back_state r_state, n_state;

    logic [CW-1:0]           r_wr_cnt;
    logic [CW-1:0]           r_n;
    logic                    r_dropped;
    logic [CW-1:0]           r_rd_idx;
    logic                    r_cmp_valid;
    logic [AW-1:0]           r_cmp_idx;
    logic                    r_best_valid;
    logic [KW:0]             r_best_key;
    logic [AW-1:0]           r_best_idx;
    logic [MAX_REQUESTS-1:0] r_served;
    logic [CW-1:0]           r_res_cnt;
    logic [KW-1:0]           r_cur;
    logic                    r_wrapped;
    logic [TOTAL_W-1:0]      r_total;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                  q_pop;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [TRACK_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [TRACK_BITS-1:0] ram_rdata;
    logic                  rd_issue;
    logic [KW-1:0]         rd_val;
    logic [KW:0]           rd_key;
    logic                  take;
    logic                  scan_done;
    logic                  out_load;
    logic                  last_res;
    logic [KW-1:0]         sel_t;
    logic [KW-1:0]         max_k;
    logic [KW-1:0]         edge_pos;
    logic                  is_wrap;
    logic [DW-1:0]         move_dist;
    logic [TOTAL_W:0]      sum;
    logic [TOTAL_W-1:0]    total_next;

    cdrs_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (q_pop && i_cmd.last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = last_res ? ST_LOAD : ST_SCAN;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop     = (r_state == ST_LOAD) && !i_q_stat.empty;
        ram_we    = q_pop && i_cmd.keep;
        ram_waddr = r_wr_cnt[AW-1:0];
        ram_wdata = TRACK_BITS'(i_cmd.track);
        rd_issue  = (r_state == ST_SCAN) && (r_rd_idx < r_n);
        ram_raddr = r_rd_idx[AW-1:0];

        // ordering key: requests below the head sort after all others
        rd_val    = KW'(ram_rdata);
        rd_key    = {rd_val < KW'(i_head_pos), rd_val};
        take      = r_cmp_valid && !r_served[r_cmp_idx]
                    && (!r_best_valid || rd_key < r_best_key);
        scan_done = (r_state == ST_SCAN) && (r_rd_idx == r_n) && !r_cmp_valid;

        out_load  = (r_state == ST_OUT) && (!r_out_valid || i_pop);
        last_res  = r_res_cnt == (r_n - CW'(1));

        sel_t     = r_best_key[KW-1:0];
        max_k     = KW'(i_max_track);
        edge_pos  = (r_cur > max_k) ? r_cur : max_k;
        is_wrap   = r_best_key[KW] && !r_wrapped;
        if (is_wrap) begin
            move_dist = DW'(edge_pos - r_cur) + DW'(edge_pos) + DW'(sel_t);
        end else if (sel_t >= r_cur) begin
            move_dist = DW'(sel_t - r_cur);
        end else begin
            move_dist = DW'(r_cur - sel_t);
        end
        sum        = {1'b0, r_total} + (TOTAL_W + 1)'(move_dist[DIST_W-1:0]);
        total_next = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_wr_cnt     <= '0;
            r_n          <= '0;
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_best_valid <= 1'b0;
            r_served     <= '0;
            r_res_cnt    <= '0;
            r_wrapped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register: refilled or emptied, never both
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (q_pop) begin
                        if (i_cmd.last) begin
                            r_n          <= r_wr_cnt + CW'(i_cmd.keep);
                            r_wr_cnt     <= '0;
                            r_served     <= '0;
                            r_res_cnt    <= '0;
                            r_wrapped    <= 1'b0;
                            r_rd_idx     <= '0;
                            r_cmp_valid  <= 1'b0;
                            r_best_valid <= 1'b0;
                        end else if (i_cmd.keep) begin
                            r_wr_cnt <= r_wr_cnt + CW'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    r_cmp_valid <= rd_issue;
                    if (rd_issue) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (take) begin
                        r_best_valid <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_served[r_best_idx] <= 1'b1;
                        r_wrapped            <= r_wrapped || r_best_key[KW];
                        r_res_cnt            <= r_res_cnt + CW'(1);
                        r_rd_idx             <= '0;
                        r_cmp_valid          <= 1'b0;
                        r_best_valid         <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (q_pop && i_cmd.last) begin
            r_dropped <= i_cmd.dropped;
            r_cur     <= KW'(i_head_pos);
            r_total   <= '0;
        end
        r_cmp_idx <= ram_raddr;
        if (take) begin
            r_best_key <= rd_key;
            r_best_idx <= r_cmp_idx;
        end
        if (out_load) begin
            r_cur                <= sel_t;
            r_total              <= total_next;
            r_out.served_track   <= sel_t[7:0];
            r_out.move_distance  <= move_dist[DIST_W-1:0];
            r_out.total_movement <= total_next;
            r_out.dropped        <= r_dropped;
            r_out.final_res      <= last_res;
        end
    end

    assign o_q_pop = q_pop;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

endmodule

>>> rtl/cdrs_checker.sv
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
module cdrs_checker import cdrs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     push,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input t_result  o_res
);

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_res))
        else $error("result changed while stalled");

    // running total covers the last move
    a_total_ge_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_res.total_movement >= TOTAL_W'(o_res.move_distance))
        else $error("total below move distance");

    // within a batch the total never falls
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_res.final_res
        |=> empty || o_res.total_movement >= $past(o_res.total_movement))
        else $error("running total decreased within batch");

    // nothing pending straight after reset
    a_reset_clean: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty && !full)
        else $error("channels not clear after reset");

endmodule

bind cscan_disk_request_scheduler cdrs_checker u_cdrs_checker (.*);
